### design/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types, codes and helpers for the hex polygon point decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Error codes
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_SHORT_HDR = 2'd1,
      ERR_BAD_HEX   = 2'd2,
      ERR_PARTIAL   = 2'd3
   } err_type;

   // Configuration register indexes
   localparam logic CSR_SCALE      = 1'b0;
   localparam logic CSR_HEADER_ENA = 1'b1;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   // Header is six hex digits
   localparam logic [2:0] HDR_DIGITS = 3'd6;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;

   // Record queue between front and back
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   // One result before scaling: a/b are x/y for a point, a/b/c header bytes
   typedef struct packed {
      kind_type   kind;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
      err_type    ecode;
   } res_type;

   // Everything one character causes: one or two results
   typedef struct packed {
      res_type r0;
      res_type r1;
      logic    two;
   } rec_type;

   // Queue status seen by front and back
   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

   // Returns {ok, value}; ok low for a non-hex character
   function automatic logic [4:0] hex_decode(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'b0;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, 4'(ch - 8'h30)};
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         r = {1'b1, 4'(ch - 8'h37)};
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         r = {1'b1, 4'(ch - 8'h57)};
      end
      return r;
   endfunction

   function automatic res_type make_point(input logic [7:0] xb, input logic [7:0] yb);
      res_type r;
      r       = '0;
      r.kind  = KIND_POINT;
      r.a     = xb;
      r.b     = yb;
      r.ecode = ERR_NONE;
      return r;
   endfunction

   function automatic res_type make_error(input err_type code);
      res_type r;
      r       = '0;
      r.kind  = KIND_ERROR;
      r.ecode = code;
      return r;
   endfunction

endpackage

### design/hpd_front.sv
// ----------------------------------------------------------------------------
// hpd_front
// Character parser: tracks header and point state and pushes one record per
// character that causes any result.
// ----------------------------------------------------------------------------
module hpd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               header_enable,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   input  hpd_pkg::qstat_type q_stat,
   output logic               push,
   output hpd_pkg::rec_type   push_rec
);
   import hpd_pkg::*;

   logic [2:0]  hcnt_ff,   hcnt_in;
   logic [23:0] hbytes_ff, hbytes_in;
   logic [1:0]  dpos_ff,   dpos_in;
   logic [7:0]  xval_ff,   xval_in;
   logic [3:0]  yhi_ff,    yhi_in;
   logic        sep_ff,    sep_in;
   logic        have_ff,   have_in;
   logic [15:0] first_ff,  first_in;
   logic        skip_ff,   skip_in;

   logic        accept;
   logic [4:0]  hv;
   logic        mv, ev, err;
   res_type     m, e;
   logic [7:0]  yb;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign hv        = hex_decode(req_char_code);

   // Parse one character
   always_comb begin
      hcnt_in   = hcnt_ff;
      hbytes_in = hbytes_ff;
      dpos_in   = dpos_ff;
      xval_in   = xval_ff;
      yhi_in    = yhi_ff;
      sep_in    = sep_ff;
      have_in   = have_ff;
      first_in  = first_ff;
      skip_in   = skip_ff;
      mv        = 1'b0;
      ev        = 1'b0;
      err       = 1'b0;
      m         = '0;
      e         = '0;
      yb        = {yhi_ff, hv[3:0]};

      if (skip_ff) begin
         // drop everything until end of string
      end else if (header_enable && hcnt_ff < HDR_DIGITS) begin
         if (!hv[4]) begin
            m   = make_error(ERR_BAD_HEX);
            mv  = 1'b1;
            err = 1'b1;
         end else begin
            hbytes_in = {hbytes_ff[19:0], hv[3:0]};
            hcnt_in   = hcnt_ff + 3'd1;
            if (hcnt_in == HDR_DIGITS) begin
               m.kind  = KIND_HEADER;
               m.a     = hbytes_in[23:16];
               m.b     = hbytes_in[15:8];
               m.c     = hbytes_in[7:0];
               m.ecode = ERR_NONE;
               mv      = 1'b1;
            end
         end
      end else if (dpos_ff == 2'd0 && req_char_code == CHAR_SPACE) begin
         // space between points
      end else if (dpos_ff == 2'd0 && req_char_code == CHAR_DOT) begin
         // close subpath
         if (have_ff && !sep_ff) begin
            m  = make_point(first_ff[15:8], first_ff[7:0]);
            mv = 1'b1;
         end
         sep_in = 1'b1;
      end else if (!hv[4]) begin
         m   = make_error(ERR_BAD_HEX);
         mv  = 1'b1;
         err = 1'b1;
      end else begin
         case (dpos_ff)
            2'd0: begin
               xval_in = {hv[3:0], 4'h0};
               dpos_in = 2'd1;
            end
            2'd1: begin
               xval_in = xval_ff | {4'h0, hv[3:0]};
               dpos_in = 2'd2;
            end
            2'd2: begin
               yhi_in  = hv[3:0];
               dpos_in = 2'd3;
            end
            default: begin
               dpos_in = 2'd0;
               m       = make_point(xval_ff, yb);
               mv      = 1'b1;
               if (!have_ff || sep_ff) begin
                  first_in = {xval_ff, yb};
                  have_in  = 1'b1;
                  sep_in   = 1'b0;
               end
            end
         endcase
      end

      if (err) begin
         skip_in = 1'b1;
      end

      // End of string checks, then clear string state
      if (req_last_char) begin
         if (!skip_in) begin
            if (header_enable && hcnt_in < HDR_DIGITS) begin
               e  = make_error(ERR_SHORT_HDR);
               ev = 1'b1;
            end else if (dpos_in != 2'd0) begin
               e  = make_error(ERR_PARTIAL);
               ev = 1'b1;
            end else if (have_in && !sep_in) begin
               e  = make_point(first_in[15:8], first_in[7:0]);
               ev = 1'b1;
            end
         end
         hcnt_in   = '0;
         hbytes_in = '0;
         dpos_in   = '0;
         xval_in   = '0;
         yhi_in    = '0;
         sep_in    = 1'b0;
         have_in   = 1'b0;
         first_in  = '0;
         skip_in   = 1'b0;
      end
   end

   // Pack results into a record
   always_comb begin
      push_rec = '0;
      if (mv) begin
         push_rec.r0  = m;
         push_rec.r1  = e;
         push_rec.two = ev;
      end else begin
         push_rec.r0  = e;
         push_rec.two = 1'b0;
      end
      push = accept && (mv || ev);
   end

   // String state
   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff   <= '0;
         hbytes_ff <= '0;
         dpos_ff   <= '0;
         xval_ff   <= '0;
         yhi_ff    <= '0;
         sep_ff    <= 1'b0;
         have_ff   <= 1'b0;
         first_ff  <= '0;
         skip_ff   <= 1'b0;
      end else if (accept) begin
         hcnt_ff   <= hcnt_in;
         hbytes_ff <= hbytes_in;
         dpos_ff   <= dpos_in;
         xval_ff   <= xval_in;
         yhi_ff    <= yhi_in;
         sep_ff    <= sep_in;
         have_ff   <= have_in;
         first_ff  <= first_in;
         skip_ff   <= skip_in;
      end
   end

endmodule

### design/hpd_queue.sv
// ----------------------------------------------------------------------------
// hpd_queue
// Small record FIFO between parser and result stage.
// ----------------------------------------------------------------------------
module hpd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hpd_pkg::rec_type   push_rec,
   input  logic               pop,
   output hpd_pkg::rec_type   head_rec,
   output hpd_pkg::qstat_type q_stat
);
   import hpd_pkg::*;

   rec_type          slot_ff [QDEPTH];
   logic [QAW-1:0]   wptr_ff, wptr_in;
   logic [QAW-1:0]   rptr_ff, rptr_in;
   logic [QAW:0]     cnt_ff,  cnt_in;
   logic             do_push, do_pop;

   assign do_push         = push && !q_stat.full;
   assign do_pop          = pop && (cnt_ff != '0);
   assign head_rec        = slot_ff[rptr_ff];
   assign q_stat.full     = (cnt_ff == (QAW+1)'(QDEPTH));
   assign q_stat.nonempty = (cnt_ff != '0);

   // Pointer and count update
   always_comb begin
      wptr_in = do_push ? wptr_ff + QAW'(1) : wptr_ff;
      rptr_in = do_pop  ? rptr_ff + QAW'(1) : rptr_ff;
      cnt_in  = cnt_ff + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Record storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_rec;
      end
   end

endmodule

### design/hpd_back.sv
// ----------------------------------------------------------------------------
// hpd_back
// Result stage: unrolls records into results, scales point coordinates and
// holds the result in the output register.
// ----------------------------------------------------------------------------
module hpd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        scale,
   input  hpd_pkg::qstat_type q_stat,
   input  hpd_pkg::rec_type   head_rec,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [15:0]        rsp_x_coord,
   output logic [15:0]        rsp_y_coord,
   output logic [7:0]         rsp_poly_type,
   output logic [7:0]         rsp_poly_color,
   output logic [7:0]         rsp_poly_layer,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_end_of_run
);
   import hpd_pkg::*;

   logic        valid_ff, valid_in;
   logic        sel_ff,   sel_in;
   logic [1:0]  kind_ff;
   logic [15:0] x_ff, y_ff;
   logic [7:0]  type_ff, color_ff, layer_ff;
   logic [1:0]  ecode_ff;
   logic        eor_ff;

   logic        load, last_of;
   res_type     cur;
   logic [23:0] prod_x, prod_y;
   logic        is_point, is_header;

   // Pick the next result out of the head record
   always_comb begin
      load      = q_stat.nonempty && (!valid_ff || !rsp_stall);
      cur       = sel_ff ? head_rec.r1 : head_rec.r0;
      last_of   = sel_ff || !head_rec.two;
      pop       = load && last_of;
      sel_in    = load ? !last_of : sel_ff;
      valid_in  = load ? 1'b1 : (valid_ff && rsp_stall);
      is_point  = (cur.kind == KIND_POINT);
      is_header = (cur.kind == KIND_HEADER);
      prod_x    = cur.a * scale;
      prod_y    = cur.b * scale;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   // Output register; byte * scale / 256 is the product's upper 16 bits
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff  <= cur.kind;
         x_ff     <= is_point  ? prod_x[23:8] : 16'h0;
         y_ff     <= is_point  ? prod_y[23:8] : 16'h0;
         type_ff  <= is_header ? cur.a : 8'h0;
         color_ff <= is_header ? cur.b : 8'h0;
         layer_ff <= is_header ? cur.c : 8'h0;
         ecode_ff <= cur.ecode;
         eor_ff   <= last_of;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_x_coord    = x_ff;
   assign rsp_y_coord    = y_ff;
   assign rsp_poly_type  = type_ff;
   assign rsp_poly_color = color_ff;
   assign rsp_poly_layer = layer_ff;
   assign rsp_error_code = ecode_ff;
   assign rsp_end_of_run = eor_ff;

endmodule

### design/hex_polygon_point_decoder.sv
// ----------------------------------------------------------------------------
// hex_polygon_point_decoder
// Decodes an ASCII-hex polygon string, one character per transfer, into
// header, point and error results.
// ----------------------------------------------------------------------------
// The block takes one character per clock. A parser resolves each character
// in the cycle it is accepted and places the one or two results it causes in
// a four-record queue; the result stage scales coordinates (one 8x16 multiply
// per coordinate) into the output register, so a result passes through the
// queue and then the output register before it is offered. A character that
// causes two results (a final point that also closes its subpath) is unrolled
// by the result stage into both, one after the other; results leave at one
// per cycle while the output is not stalled. The input stalls only when the
// queue is full. Write scale and header_enable only while idle.
module hex_polygon_point_decoder (
   input  logic        clock,
   input  logic        reset,
   // character input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   input  logic        req_last_char,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_x_coord,
   output logic [15:0] rsp_y_coord,
   output logic [7:0]  rsp_poly_type,
   output logic [7:0]  rsp_poly_color,
   output logic [7:0]  rsp_poly_layer,
   output logic [1:0]  rsp_error_code,
   output logic        rsp_end_of_run,
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import hpd_pkg::*;

   logic [15:0] scale_ff;
   logic        hdr_ena_ff;

   logic        push, pop;
   rec_type     push_rec, head_rec;
   qstat_type   q_stat;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff   <= SCALE_RESET;
         hdr_ena_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCALE:      scale_ff   <= csr_wdata;
            CSR_HEADER_ENA: hdr_ena_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   hpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .header_enable (hdr_ena_ff),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_stat        (q_stat),
      .push          (push),
      .push_rec      (push_rec)
   );

   hpd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .head_rec (head_rec),
      .q_stat   (q_stat)
   );

   hpd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .scale          (scale_ff),
      .q_stat         (q_stat),
      .head_rec       (head_rec),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_x_coord    (rsp_x_coord),
      .rsp_y_coord    (rsp_y_coord),
      .rsp_poly_type  (rsp_poly_type),
      .rsp_poly_color (rsp_poly_color),
      .rsp_poly_layer (rsp_poly_layer),
      .rsp_error_code (rsp_error_code),
      .rsp_end_of_run (rsp_end_of_run)
   );

`ifndef NO_ASSERTIONS
   // Nothing leaves the block right after reset
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Error results carry a code and no coordinates
   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ERROR) |->
         (rsp_error_code != ERR_NONE && rsp_x_coord == 16'h0 && rsp_y_coord == 16'h0))
      else $error("malformed error result");

   // Point results carry no type or layer byte and no error code
   a_point_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_POINT) |->
         (rsp_error_code == ERR_NONE && rsp_poly_type == 8'h0 && rsp_poly_layer == 8'h0))
      else $error("malformed point result");

   // Header results only appear with the header mode on
   a_header_mode: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_HEADER) |-> hdr_ena_ff)
      else $error("header result with header mode off");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hex polygon point decoder. Characters go in one
// transfer at a time; a behavioral decoder inside the bench predicts the
// header, point and error results, and each result transfer is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hpd_pkg::*;

   // ASCII anchors for building hex digits
   localparam logic [7:0] DIGIT_ZERO = 8'h30;
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] LOWER_A    = 8'h61;

   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic [7:0]  poly_type;
      logic [7:0]  poly_color;
      logic [7:0]  poly_layer;
      err_type     error_code;
      logic        end_of_run;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [15:0] rsp_x_coord;
   logic [15:0] rsp_y_coord;
   logic [7:0]  rsp_poly_type;
   logic [7:0]  rsp_poly_color;
   logic [7:0]  rsp_poly_layer;
   logic [1:0]  rsp_error_code;
   logic        rsp_end_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_wdata = 16'h0000;

   hex_polygon_point_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_code  (req_char_code),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_x_coord    (rsp_x_coord),
      .rsp_y_coord    (rsp_y_coord),
      .rsp_poly_type  (rsp_poly_type),
      .rsp_poly_color (rsp_poly_color),
      .rsp_poly_layer (rsp_poly_layer),
      .rsp_error_code (rsp_error_code),
      .rsp_end_of_run (rsp_end_of_run),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // Shadow registers and string state of the predicted decoder
   logic [15:0] cfg_scale = SCALE_RESET;
   logic        cfg_hdr_on = 1'b0;
   logic [2:0]  hdr_count;
   logic [23:0] hdr_bytes;
   logic [1:0]  nib_pos;
   logic [7:0]  x_byte;
   logic [3:0]  y_hi;
   logic        sep_seen;
   logic        open_path;
   logic [15:0] path_start;
   logic        skip_rest;

   decoded_type pending_results[$];

   int error_count     = 0;
   int chars_sent      = 0;
   int strings_sent    = 0;
   int results_checked = 0;
   int idle_pct        = 30;
   int hold_req        = 0;
   int hold_ack        = 0;
   int hold_left       = 0;
   int stall_left      = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
      $display("testbench: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predicted decoder
   // ------------------------------------------------------------------
   function automatic int nibble_of(input logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return ch - "0";
      if (ch >= "A" && ch <= "F") return ch - "A" + 10;
      if (ch >= "a" && ch <= "f") return ch - "a" + 10;
      return -1;
   endfunction

   function automatic decoded_type point_result(input logic [7:0] xb, input logic [7:0] yb);
      decoded_type r;
      r            = '0;
      r.kind       = KIND_POINT;
      r.x_coord    = 16'((32'(xb) * 32'(cfg_scale)) >> 8);
      r.y_coord    = 16'((32'(yb) * 32'(cfg_scale)) >> 8);
      r.error_code = ERR_NONE;
      return r;
   endfunction

   function automatic decoded_type error_result(input err_type code);
      decoded_type r;
      r            = '0;
      r.kind       = KIND_ERROR;
      r.error_code = code;
      return r;
   endfunction

   task automatic clear_string_state();
      hdr_count  = '0;
      hdr_bytes  = '0;
      nib_pos    = '0;
      x_byte     = '0;
      y_hi       = '0;
      sep_seen   = 1'b0;
      open_path  = 1'b0;
      path_start = '0;
      skip_rest  = 1'b0;
   endtask

   // Advance the predicted state by one character and queue its results
   task automatic decode_char(input logic [7:0] ch, input logic last);
      decoded_type outs[$];
      decoded_type hdr;
      int          nib;
      logic        bad;
      nib = nibble_of(ch);
      bad = 1'b0;
      if (skip_rest) begin
         // after an error everything up to the end of string is dropped
      end else if (cfg_hdr_on && hdr_count < HDR_DIGITS) begin
         if (nib < 0) begin
            outs.push_back(error_result(ERR_BAD_HEX));
            bad = 1'b1;
         end else begin
            hdr_bytes = {hdr_bytes[19:0], nib[3:0]};
            hdr_count++;
            if (hdr_count == HDR_DIGITS) begin
               hdr            = '0;
               hdr.kind       = KIND_HEADER;
               hdr.poly_type  = hdr_bytes[23:16];
               hdr.poly_color = hdr_bytes[15:8];
               hdr.poly_layer = hdr_bytes[7:0];
               hdr.error_code = ERR_NONE;
               outs.push_back(hdr);
            end
         end
      end else if (nib_pos == 2'd0 && ch == CHAR_SPACE) begin
         // space between points
      end else if (nib_pos == 2'd0 && ch == CHAR_DOT) begin
         // close subpath; nothing if no point since the last dot
         if (open_path && !sep_seen) begin
            outs.push_back(point_result(path_start[15:8], path_start[7:0]));
         end
         sep_seen = 1'b1;
      end else if (nib < 0) begin
         outs.push_back(error_result(ERR_BAD_HEX));
         bad = 1'b1;
      end else begin
         case (nib_pos)
            2'd0: begin
               x_byte  = {nib[3:0], 4'h0};
               nib_pos = 2'd1;
            end
            2'd1: begin
               x_byte[3:0] = nib[3:0];
               nib_pos     = 2'd2;
            end
            2'd2: begin
               y_hi    = nib[3:0];
               nib_pos = 2'd3;
            end
            default: begin
               outs.push_back(point_result(x_byte, {y_hi, nib[3:0]}));
               nib_pos = 2'd0;
               // first point of a new subpath is remembered for the close
               if (!open_path || sep_seen) begin
                  path_start = {x_byte, y_hi, nib[3:0]};
                  open_path  = 1'b1;
                  sep_seen   = 1'b0;
               end
            end
         endcase
      end
      if (bad) skip_rest = 1'b1;
      // end of string: short header, then partial point, then implicit close
      if (last) begin
         if (!skip_rest) begin
            if (cfg_hdr_on && hdr_count < HDR_DIGITS) begin
               outs.push_back(error_result(ERR_SHORT_HDR));
            end else if (nib_pos != 2'd0) begin
               outs.push_back(error_result(ERR_PARTIAL));
            end else if (open_path && !sep_seen) begin
               outs.push_back(point_result(path_start[15:8], path_start[7:0]));
            end
         end
         clear_string_state();
      end
      if (outs.size() > 0) outs[outs.size() - 1].end_of_run = 1'b1;
      foreach (outs[i]) pending_results.push_back(outs[i]);
   endtask

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic check_field(input string field_name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name, want, got);
         error_count++;
      end
   endtask

   // Outputs and stall are stable at the falling edge; a transfer seen here
   // completes at the next rising edge
   always @(negedge clock) begin
      decoded_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, kind %0d x %0h y %0h error %0d", $time,
                     rsp_kind, rsp_x_coord, rsp_y_coord, rsp_error_code);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("x_coord", want.x_coord, rsp_x_coord);
            check_field("y_coord", want.y_coord, rsp_y_coord);
            check_field("poly_type", want.poly_type, rsp_poly_type);
            check_field("poly_color", want.poly_color, rsp_poly_color);
            check_field("poly_layer", want.poly_layer, rsp_poly_layer);
            check_field("error_code", want.error_code, rsp_error_code);
            check_field("end_of_run", want.end_of_run, rsp_end_of_run);
            results_checked++;
         end
      end
   end

   // Mostly short idle stretches, a few long ones; none when idle_pct is 0
   function automatic int idle_length();
      if ($urandom_range(99) >= idle_pct) return 0;
      if ($urandom_range(9) == 0) return $urandom_range(30, 10);
      return $urandom_range(3, 1);
   endfunction

   // Receiver stall: long hold on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_req != hold_ack) begin
         hold_ack = hold_req;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = idle_length();
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   // One character transfer; valid stays high across back-to-back items
   task automatic send_char(input logic [7:0] ch, input logic last);
      int gap;
      req_valid     <= 1'b1;
      req_char_code <= ch;
      req_last_char <= last;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      decode_char(ch, last);
      chars_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_string(input string text);
      for (int i = 0; i < text.len(); i++) send_char(text[i], i == text.len() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Register write while idle; extra cycles cover characters still in flight
   task automatic write_register(input logic idx, input logic [15:0] value);
      wait_drained();
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SCALE) cfg_scale = value;
      else cfg_hdr_on = value[0];
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return DIGIT_ZERO + 8'(v);
      if ($urandom_range(1) == 0) return UPPER_A + 8'(v) - 8'd10;
      return LOWER_A + 8'(v) - 8'd10;
   endfunction

   // Mostly well-formed strings; some truncated, some with a stray byte
   task automatic send_random_string();
      logic [7:0] text[$];
      int         style;
      int         cut;
      style = $urandom_range(99);
      if (cfg_hdr_on) repeat (6) text.push_back(hex_char(4'($urandom_range(15))));
      repeat ($urandom_range(6, 1)) begin
         if ($urandom_range(4) == 0) text.push_back(CHAR_DOT);
         repeat (4) text.push_back(hex_char(4'($urandom_range(15))));
         if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) text.push_back(CHAR_SPACE);
      end
      if ($urandom_range(5) == 0) text.push_back(CHAR_DOT);
      if (style >= 88) begin
         text.insert($urandom_range(text.size() - 1), 8'($urandom_range(255)));
      end else if (style >= 75) begin
         cut = $urandom_range(text.size() - 1, 1);
         repeat (cut) void'(text.pop_back());
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
      strings_sent++;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Mixed-case digits, space, dot close, close on last char, empty close
   task automatic test_point_syntax();
      send_string("0Ff0 .a9B7");
      send_string(".");
   endtask

   // Full header with a point at maximum scale, short header, bad header digit
   task automatic test_header();
      write_register(CSR_HEADER_ENA, 1'b1);
      write_register(CSR_SCALE, 16'hFFFF);
      send_string("A1b2C312fE");
      send_string("12");
      send_string("1G");
   endtask

   // Partial point, space inside a point, NUL while skipping, error on last
   task automatic test_error_paths();
      write_register(CSR_HEADER_ENA, 1'b0);
      write_register(CSR_SCALE, 16'h0000);
      send_string("5");
      send_char("1", 1'b0);
      send_char(CHAR_SPACE, 1'b0);
      send_char(8'h00, 1'b0);
      send_char("5", 1'b1);
      send_char(8'hFF, 1'b1);
   endtask

   // Receiver holds off while characters keep coming, filling the queue
   task automatic test_output_hold();
      write_register(CSR_SCALE, 16'(SCALE_RESET));
      idle_pct = 0;
      hold_req++;
      repeat (6) send_random_string();
      wait_drained();
      idle_pct = 30;
   endtask

   task automatic test_random_strings();
      int target;
      for (int phase = 0; phase < 10; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_SCALE, 16'd256);
               write_register(CSR_HEADER_ENA, 1'b0);
            end
            1: begin
               write_register(CSR_SCALE, 16'd0);
               write_register(CSR_HEADER_ENA, 1'b1);
            end
            2: begin
               write_register(CSR_SCALE, 16'hFFFF);
               write_register(CSR_HEADER_ENA, 1'b0);
            end
            3: begin
               write_register(CSR_SCALE, 16'd1);
               write_register(CSR_HEADER_ENA, 1'b1);
            end
            4: begin
               write_register(CSR_SCALE, 16'd255);
               write_register(CSR_HEADER_ENA, 1'b0);
            end
            default: begin
               write_register(CSR_SCALE, 16'($urandom_range(65535)));
               write_register(CSR_HEADER_ENA, 1'($urandom_range(1)));
            end
         endcase
         // some phases run without any idle cycles on either side
         idle_pct = (phase % 4 == 2) ? 0 : 30;
         target = chars_sent + 100;
         while (chars_sent < target) begin
            send_random_string();
            if ($urandom_range(7) == 0) wait_drained();
         end
      end
      idle_pct = 30;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_string_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_point_syntax();
      test_header();
      test_error_paths();
      test_output_hold();
      test_random_strings();
      wait_drained();
      repeat (20) @(posedge clock);
      $display("summary: %0d characters, %0d random strings, %0d results checked",
               chars_sent, strings_sent, results_checked);
      $display("summary: scale extremes, header on and off, errors, output hold, drains");
      if (error_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
